### sv/tansd_pkg.sv
package tansd_pkg;

    // Decoding table geometry
    localparam int TBL_BITS   = 6;
    localparam int TABLE_SIZE = 1 << TBL_BITS;
    localparam int NUM_SYM    = 16;
    localparam int SYM_IDX_W  = $clog2(NUM_SYM);

    // Widths of the derived column entries
    localparam int BASE_W = 12;   // prefix sum of up to 16 byte counts
    localparam int Y_W    = 9;    // y below twice the largest count
    localparam int K_W    = 3;    // shift never above TBL_BITS for a hit

    // Configuration register indexes
    localparam logic [1:0] REG_SYMBOLS_LOW  = 2'd0;
    localparam logic [1:0] REG_SYMBOLS_HIGH = 2'd1;
    localparam logic [1:0] REG_COUNTS_LOW   = 2'd2;
    localparam logic [1:0] REG_COUNTS_HIGH  = 2'd3;

    // Command codes carried on s_tuser
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    // Prefix sweep sequencer
    typedef enum logic [1:0] {
        SW_IDLE,
        SW_SWEEP,
        SW_REFRESH
    } sw_state_t;

    // One column of the decoding table
    typedef struct packed {
        logic [7:0]     sym;
        logic [Y_W-1:0] y;
        logic [K_W-1:0] k;
    } col_entry_t;

endpackage

### sv/tans_symbol_decoder.sv
// Channel  | Dir | Beat contents
// s_*      | in  | tuser: cmd; tdata: initial_column[5:0], bit_window[11:6], zeros[15:12]
// m_*      | out | tdata: symbol[7:0], bits_used[10:8], table_error[11], zeros[15:12]
// cfg_*    | in  | cfg_index selects register 0..3, cfg_data is the 64-bit value
//
// One beat per cycle while m_tready is high and no sweep runs; a result beat goes through
// the input register, then one pass of column lookup into the result register.
// The running column, with its y and k, is kept so each step needs one table lookup.
// A write to either counts register starts a prefix-sum sweep over the 16 symbols, one
// symbol a cycle, then a refresh of the current column's y and k; s_tready is low then.
// Async reset (rst_n low) clears control state, sets sum_bad_reg; the start column is 0.
// Stalls on m_tready hold the result register and back up through the input register.
module tans_symbol_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [5:0] initial_column, [11:6] bit_window, [15:12] zero
    input  logic        s_tuser,    // [0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [7:0] symbol, [10:8] bits_used, [11] table_error
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int TB  = tansd_pkg::TBL_BITS;
    localparam int NS  = tansd_pkg::NUM_SYM;
    localparam int IW  = tansd_pkg::SYM_IDX_W;
    localparam int BW  = tansd_pkg::BASE_W;
    localparam int YW  = tansd_pkg::Y_W;
    localparam int KW  = tansd_pkg::K_W;

    // Configuration registers
    logic [63:0] sym_lo_reg, sym_hi_reg, cnt_lo_reg, cnt_hi_reg;
    logic [127:0] sym_all, cnt_all;
    logic        cfg_wr, cnt_wr;

    // Prefix sweep state
    tansd_pkg::sw_state_t sw_state_reg, sw_state_next;
    logic [IW-1:0] sw_idx_reg, sw_idx_next;
    logic [BW-1:0] sw_acc_reg, sw_acc_next;
    logic [BW-1:0] base_reg [NS];
    logic          sum_bad_reg, sum_bad_next;
    logic          base_wr;

    // Input and result registers
    logic          in_valid_reg;
    logic          in_cmd_reg;
    logic [TB-1:0] in_init_reg, in_win_reg;
    logic          out_valid_reg;
    logic [7:0]    out_sym_reg;
    logic [KW-1:0] out_used_reg;
    logic          out_err_reg;

    // Running decoder state
    logic [TB-1:0] cur_col_reg, cur_col_next;
    logic [YW-1:0] cur_y_reg;
    logic [KW-1:0] cur_k_reg;

    logic          advance, in_take;
    logic [TB-1:0] win_mask, step_bits;
    logic [15:0]   step_state;
    logic          step_ok, item_err;
    logic [TB-1:0] lk_col;
    tansd_pkg::col_entry_t lk;

    assign sym_all = {sym_hi_reg, sym_lo_reg};
    assign cnt_all = {cnt_hi_reg, cnt_lo_reg};

    // Column lookup: first symbol whose run covers column c
    function automatic tansd_pkg::col_entry_t col_lookup(
        input logic [TB-1:0]  c,
        input logic [127:0]   cnts,
        input logic [127:0]   syms,
        input logic [NS*BW-1:0] bases
    );
        tansd_pkg::col_entry_t e;
        logic [BW-1:0] cw, b, f, off;
        logic [YW-1:0] y;
        e = '0;
        cw = BW'(c);
        for (int n = NS - 1; n >= 0; n--)
        begin
            b   = bases[n*BW +: BW];
            f   = BW'(cnts[n*8 +: 8]);
            off = cw - b;
            if (cw >= b && cw < b + f)
            begin
                y     = YW'(f + off);
                e.sym = syms[n*8 +: 8];
                e.y   = y;
                e.k   = KW'(TB);
                for (int s = TB; s >= 0; s--)
                begin
                    if ((y >> (TB - s)) != '0)
                    begin
                        e.k = KW'(s);
                    end
                end
            end
        end
        return e;
    endfunction

    logic [NS*BW-1:0] base_flat;
    always_comb
    begin
        for (int n = 0; n < NS; n++)
        begin
            base_flat[n*BW +: BW] = base_reg[n];
        end
    end

    // Configuration writes
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign cnt_wr    = cfg_wr && (cfg_index == tansd_pkg::REG_COUNTS_LOW ||
                                  cfg_index == tansd_pkg::REG_COUNTS_HIGH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sym_lo_reg <= '0;
            sym_hi_reg <= '0;
            cnt_lo_reg <= '0;
            cnt_hi_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                tansd_pkg::REG_SYMBOLS_LOW:  sym_lo_reg <= cfg_data;
                tansd_pkg::REG_SYMBOLS_HIGH: sym_hi_reg <= cfg_data;
                tansd_pkg::REG_COUNTS_LOW:   cnt_lo_reg <= cfg_data;
                tansd_pkg::REG_COUNTS_HIGH:  cnt_hi_reg <= cfg_data;
                default:                     sym_lo_reg <= sym_lo_reg;
            endcase
        end
    end

    // Sweep sequencer: accumulate run bases one symbol a cycle
    always_comb
    begin
        sw_state_next = sw_state_reg;
        sw_idx_next   = sw_idx_reg;
        sw_acc_next   = sw_acc_reg;
        sum_bad_next  = sum_bad_reg;
        base_wr       = 1'b0;
        case (sw_state_reg)
            tansd_pkg::SW_IDLE:
            begin
            end
            tansd_pkg::SW_SWEEP:
            begin
                base_wr     = 1'b1;
                sw_acc_next = sw_acc_reg + BW'(cnt_all[sw_idx_reg*8 +: 8]);
                sw_idx_next = sw_idx_reg + 1'b1;
                if (sw_idx_reg == IW'(NS - 1))
                begin
                    sum_bad_next  = (sw_acc_next != BW'(tansd_pkg::TABLE_SIZE));
                    sw_state_next = tansd_pkg::SW_REFRESH;
                end
            end
            tansd_pkg::SW_REFRESH:
            begin
                sw_state_next = tansd_pkg::SW_IDLE;
            end
            default:
            begin
                sw_state_next = tansd_pkg::SW_IDLE;
            end
        endcase
        // A new count write restarts the sweep
        if (cnt_wr)
        begin
            sw_state_next = tansd_pkg::SW_SWEEP;
            sw_idx_next   = '0;
            sw_acc_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_state_reg <= tansd_pkg::SW_IDLE;
            sw_idx_reg   <= '0;
            sw_acc_reg   <= '0;
            sum_bad_reg  <= 1'b1;
            for (int n = 0; n < NS; n++)
            begin
                base_reg[n] <= '0;
            end
        end
        else
        begin
            sw_state_reg <= sw_state_next;
            sw_idx_reg   <= sw_idx_next;
            sw_acc_reg   <= sw_acc_next;
            sum_bad_reg  <= sum_bad_next;
            if (base_wr)
            begin
                base_reg[sw_idx_reg] <= sw_acc_reg;
            end
        end
    end

    // Handshake: result register frees the input register
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = (sw_state_reg == tansd_pkg::SW_IDLE) && (!in_valid_reg || advance);
    assign in_take  = s_tvalid && s_tready;

    // Step: consume k window bits and move to (y << k) + bits
    assign win_mask   = TB'((16'd1 << cur_k_reg) - 16'd1);
    assign step_bits  = in_win_reg & win_mask;
    assign step_state = (16'(cur_y_reg) << cur_k_reg) + 16'(step_bits);
    assign step_ok    = (step_state[15:TB] == 10'd1);

    always_comb
    begin
        if (in_cmd_reg == tansd_pkg::CMD_START)
        begin
            cur_col_next = in_init_reg;
            item_err     = sum_bad_reg;
        end
        else
        begin
            cur_col_next = step_ok ? step_state[TB-1:0] : '0;
            item_err     = sum_bad_reg || !step_ok;
        end
    end

    // Single lookup: new column on items, held column on refresh
    assign lk_col = (sw_state_reg == tansd_pkg::SW_REFRESH) ? cur_col_reg : cur_col_next;
    assign lk     = col_lookup(lk_col, cnt_all, sym_all, base_flat);

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_cmd_reg  <= s_tuser;
            in_init_reg <= s_tdata[5:0];
            in_win_reg  <= s_tdata[11:6];
        end
    end

    // Result register and running state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            cur_col_reg   <= '0;
            cur_y_reg     <= '0;
            cur_k_reg     <= '0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                cur_col_reg   <= cur_col_next;
                cur_y_reg     <= lk.y;
                cur_k_reg     <= lk.k;
            end
            else
            begin
                if (m_tready)
                begin
                    out_valid_reg <= 1'b0;
                end
                if (sw_state_reg == tansd_pkg::SW_REFRESH)
                begin
                    cur_y_reg <= lk.y;
                    cur_k_reg <= lk.k;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_sym_reg  <= lk.sym;
            out_used_reg <= (in_cmd_reg == tansd_pkg::CMD_START) ? '0 : cur_k_reg;
            out_err_reg  <= item_err;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_err_reg, out_used_reg, out_sym_reg};

endmodule

### sv/tansd_chk.sv
module tansd_chk
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [1:0]  cfg_index
);

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed under stall");

    // Never consume more window bits than the table depth allows
    a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[10:8] <= 3'd6)
        else $error("bits_used out of range");

    // Keep padding bits clear
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[15:12] == 4'd0)
        else $error("tdata padding not zero");

    // Drop s_tready once a count write starts the sweep
    a_sweep_block: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready && (cfg_index == tansd_pkg::REG_COUNTS_LOW ||
                                   cfg_index == tansd_pkg::REG_COUNTS_HIGH) |=> !s_tready)
        else $error("input accepted during count sweep");

endmodule

bind tans_symbol_decoder tansd_chk u_tansd_chk
(
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index)
);

### sim/tb_tans_symbol_decoder.sv
`timescale 1ns / 100ps

module tb_tans_symbol_decoder;

    localparam int ITEMS_PER_PHASE = 125;
    localparam int RANDOM_PHASES   = 10;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int STALL_LIMIT     = 2000;
    localparam int DIRECTED_ROWS   = 22;

    typedef struct packed {
        logic [7:0] symbol;
        logic [2:0] bits_used;
        logic       table_error;
    } beat_result_t;

    // Tables loaded by the directed part
    typedef enum logic [1:0] {
        TBL_CLEARED,
        TBL_SKEWED,
        TBL_OVERSIZE,
        TBL_SHORT
    } table_id_t;

    typedef struct packed {
        table_id_t    tbl;
        logic         cmd;
        logic [5:0]   column;
        logic [5:0]   window;
        logic         typed;
        beat_result_t res;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;    // [5:0] initial_column, [11:6] bit_window, [15:12] zero
    logic        s_tuser;    // [0] cmd
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;    // [7:0] symbol, [10:8] bits_used, [11] table_error
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;

    // Predictor copy of the registers and the running column
    logic [63:0]  pred_regs [4];
    int unsigned  pred_column;
    beat_result_t expected_results [$];

    int mismatches;
    int idle_cycles;
    bit no_idle;
    bit hold_off_req;

    // Directed beats; typed rows carry their result, the rest go through the predictor
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{TBL_CLEARED,  tansd_pkg::CMD_START, 6'd0,  6'd0,  1'b1, '{8'h00, 3'd0, 1'b1}},
        '{TBL_CLEARED,  tansd_pkg::CMD_START, 6'd63, 6'd0,  1'b1, '{8'h00, 3'd0, 1'b1}},
        '{TBL_CLEARED,  tansd_pkg::CMD_STEP,  6'd0,  6'd63, 1'b1, '{8'h00, 3'd0, 1'b1}},
        '{TBL_CLEARED,  tansd_pkg::CMD_STEP,  6'd0,  6'd0,  1'b1, '{8'h00, 3'd0, 1'b1}},
        '{TBL_SKEWED,   tansd_pkg::CMD_START, 6'd0,  6'd0,  1'b1, '{8'h00, 3'd0, 1'b0}},
        '{TBL_SKEWED,   tansd_pkg::CMD_STEP,  6'd0,  6'd63, 1'b1, '{8'hFF, 3'd6, 1'b0}},
        '{TBL_SKEWED,   tansd_pkg::CMD_STEP,  6'd0,  6'd0,  1'b0, '0},
        '{TBL_SKEWED,   tansd_pkg::CMD_STEP,  6'd0,  6'd42, 1'b0, '0},
        '{TBL_SKEWED,   tansd_pkg::CMD_START, 6'd1,  6'd0,  1'b0, '0},
        '{TBL_SKEWED,   tansd_pkg::CMD_STEP,  6'd0,  6'd63, 1'b0, '0},
        '{TBL_SKEWED,   tansd_pkg::CMD_START, 6'd32, 6'd0,  1'b0, '0},
        '{TBL_SKEWED,   tansd_pkg::CMD_STEP,  6'd0,  6'd21, 1'b0, '0},
        '{TBL_SKEWED,   tansd_pkg::CMD_START, 6'd63, 6'd0,  1'b0, '0},
        '{TBL_SKEWED,   tansd_pkg::CMD_STEP,  6'd0,  6'd63, 1'b0, '0},
        '{TBL_OVERSIZE, tansd_pkg::CMD_START, 6'd5,  6'd0,  1'b1, '{8'hFF, 3'd0, 1'b1}},
        '{TBL_OVERSIZE, tansd_pkg::CMD_STEP,  6'd0,  6'd63, 1'b1, '{8'hFF, 3'd0, 1'b1}},
        '{TBL_OVERSIZE, tansd_pkg::CMD_STEP,  6'd0,  6'd0,  1'b1, '{8'hFF, 3'd0, 1'b1}},
        '{TBL_SHORT,    tansd_pkg::CMD_START, 6'd40, 6'd0,  1'b1, '{8'h00, 3'd0, 1'b1}},
        '{TBL_SHORT,    tansd_pkg::CMD_STEP,  6'd0,  6'd7,  1'b0, '0},
        '{TBL_SHORT,    tansd_pkg::CMD_START, 6'd0,  6'd0,  1'b0, '0},
        '{TBL_SHORT,    tansd_pkg::CMD_STEP,  6'd0,  6'd63, 1'b0, '0},
        '{TBL_SHORT,    tansd_pkg::CMD_STEP,  6'd0,  6'd0,  1'b0, '0}
    };

    tans_symbol_decoder u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic int unsigned count_of(input int unsigned n);
        logic [63:0] word;
        word = (n < 8) ? pred_regs[tansd_pkg::REG_COUNTS_LOW]
                       : pred_regs[tansd_pkg::REG_COUNTS_HIGH];
        return word[(n % 8) * 8 +: 8];
    endfunction

    function automatic logic [7:0] symbol_of(input int unsigned n);
        logic [63:0] word;
        word = (n < 8) ? pred_regs[tansd_pkg::REG_SYMBOLS_LOW]
                       : pred_regs[tansd_pkg::REG_SYMBOLS_HIGH];
        return word[(n % 8) * 8 +: 8];
    endfunction

    // Find the run holding column c; an uncovered column gives symbol 0, y 0, k 0
    function automatic void lookup_column(input int unsigned c, output logic [7:0] sym,
                                          output int unsigned y, output int unsigned k);
        int unsigned base;
        int unsigned f;
        sym  = 8'h00;
        y    = 0;
        k    = 0;
        base = 0;
        for (int unsigned n = 0; n < tansd_pkg::NUM_SYM; n++)
        begin
            f = count_of(n);
            if (c >= base && c < base + f)
            begin
                y = f + (c - base);
                while (k < 16 && (y << k) < tansd_pkg::TABLE_SIZE)
                    k++;
                sym = symbol_of(n);
                return;
            end
            base += f;
        end
    endfunction

    // Advance the running column by one beat and form its result
    function automatic beat_result_t decode_beat(input logic cmd, input logic [5:0] column,
                                                 input logic [5:0] window);
        int unsigned  total;
        int unsigned  y;
        int unsigned  k;
        int unsigned  bits;
        int unsigned  next_state;
        int unsigned  used;
        logic [7:0]   sym;
        beat_result_t r;
        total = 0;
        for (int unsigned n = 0; n < tansd_pkg::NUM_SYM; n++)
            total += count_of(n);
        r.table_error = (total != tansd_pkg::TABLE_SIZE);
        used = 0;
        if (cmd == tansd_pkg::CMD_START)
        begin
            pred_column = column;
        end
        else
        begin
            lookup_column(pred_column, sym, y, k);
            bits       = (k >= tansd_pkg::TBL_BITS) ? window : (window & ((1 << k) - 1));
            next_state = (y << k) + bits;
            used       = k;
            if (next_state >= tansd_pkg::TABLE_SIZE && next_state < 2 * tansd_pkg::TABLE_SIZE)
            begin
                pred_column = next_state - tansd_pkg::TABLE_SIZE;
            end
            else
            begin
                pred_column   = 0;
                r.table_error = 1'b1;
            end
        end
        lookup_column(pred_column, sym, y, k);
        r.symbol    = sym;
        r.bits_used = used[2:0];
        return r;
    endfunction

    // Mostly back to back, a few short gaps and the odd long one
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one beat, wait for it to be taken, and queue its expected result
    task automatic send_beat(input logic cmd, input logic [5:0] column,
                             input logic [5:0] window, input logic typed,
                             input beat_result_t typed_res);
        int           gap;
        beat_result_t r;
        gap = pick_gap();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'b0000, window, column};
        do
            @(posedge clk);
        while (!s_tready);
        r = decode_beat(cmd, column, window);
        expected_results = {expected_results, (typed ? typed_res : r)};
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        pred_regs[idx] = value;
        @(negedge clk);
    endtask

    task automatic load_table(input logic [63:0] syms_lo, input logic [63:0] syms_hi,
                              input logic [63:0] counts_lo, input logic [63:0] counts_hi);
        write_reg(tansd_pkg::REG_SYMBOLS_LOW, syms_lo);
        write_reg(tansd_pkg::REG_SYMBOLS_HIGH, syms_hi);
        write_reg(tansd_pkg::REG_COUNTS_LOW, counts_lo);
        write_reg(tansd_pkg::REG_COUNTS_HIGH, counts_hi);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_named_table(input table_id_t id);
        case (id)
            // counts 1,31,16,8,4,2,1,1 sum to the table size
            TBL_SKEWED:
                load_table(64'hFF66_5544_3322_1100, 64'hA5A5_5A5A_FFFF_0000,
                           64'h0101_0204_0810_1F01, 64'h0);
            // one symbol with the largest count, far over the table size
            TBL_OVERSIZE:
                load_table({64{1'b1}}, {64{1'b1}}, 64'h0000_0000_0000_00FF, 64'h0);
            // only the last symbol, covering half the columns
            TBL_SHORT:
                load_table({64{1'b1}}, 64'h5A00_0000_0000_0000, 64'h0, 64'h2000_0000_0000_0000);
            default:
                load_table(64'h0, 64'h0, 64'h0, 64'h0);
        endcase
    endtask

    // Spread the table size over a random number of symbols, optionally off by one
    task automatic random_counts(input bit nudge, output logic [63:0] lo, output logic [63:0] hi);
        int unsigned cnt [16];
        int unsigned used_syms;
        int unsigned pick;
        foreach (cnt[i])
            cnt[i] = 0;
        used_syms = $urandom_range(1, tansd_pkg::NUM_SYM);
        for (int n = 0; n < tansd_pkg::TABLE_SIZE; n++)
            cnt[$urandom_range(0, used_syms - 1)]++;
        if (nudge)
        begin
            pick = $urandom_range(0, tansd_pkg::NUM_SYM - 1);
            if (cnt[pick] == 0 || $urandom_range(0, 1) == 1)
                cnt[pick]++;
            else
                cnt[pick]--;
        end
        lo = '0;
        hi = '0;
        for (int n = 0; n < tansd_pkg::NUM_SYM; n++)
        begin
            if (n < 8)
                lo[n * 8 +: 8] = 8'(cnt[n]);
            else
                hi[(n - 8) * 8 +: 8] = 8'(cnt[n]);
        end
    endtask

    // Drop valid and wait for every queued result to come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Receiver pacing, with one long hold-off on request
    initial
    begin : sink_pacing
        int gap;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                gap = HOLD_OFF_CYCLES;
            end
            else
            begin
                gap = pick_gap();
            end
            if (gap != 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // Compare each result beat with the oldest expectation
    always @(posedge clk)
    begin : check_results
        beat_result_t want;
        beat_result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.symbol      = m_tdata[7:0];
            got.bits_used   = m_tdata[10:8];
            got.table_error = m_tdata[11];
            if (expected_results.size() == 0)
            begin
                $display("%0t: result beat with nothing expected, got %03h", $time, m_tdata[11:0]);
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.symbol !== want.symbol)
                begin
                    $display("%0t: symbol expected %02h, got %02h", $time, want.symbol, got.symbol);
                    mismatches++;
                end
                if (got.bits_used !== want.bits_used)
                begin
                    $display("%0t: bits_used expected %0d, got %0d",
                             $time, want.bits_used, got.bits_used);
                    mismatches++;
                end
                if (got.table_error !== want.table_error)
                begin
                    $display("%0t: table_error expected %0b, got %0b",
                             $time, want.table_error, got.table_error);
                    mismatches++;
                end
            end
        end
    end

    // End the run when no beat moves on any channel for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("FAIL tans_symbol_decoder");
            $finish;
        end
    end

    initial
    begin : stimulus
        table_id_t   cur_tbl;
        logic [63:0] counts_lo;
        logic [63:0] counts_hi;
        logic [7:0]  mask;
        int          kind;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = tansd_pkg::CMD_START;
        cfg_valid    = 1'b0;
        cfg_index    = tansd_pkg::REG_SYMBOLS_LOW;
        cfg_data     = '0;
        mismatches   = 0;
        idle_cycles  = 0;
        no_idle      = 1'b0;
        hold_off_req = 1'b0;
        pred_column  = 0;
        foreach (pred_regs[i])
            pred_regs[i] = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed beats, loading each table as the rows move on to it
        cur_tbl = TBL_CLEARED;
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].tbl != cur_tbl)
            begin
                cur_tbl = directed_rows[i].tbl;
                drain_results();
                load_named_table(cur_tbl);
            end
            send_beat(directed_rows[i].cmd, directed_rows[i].column, directed_rows[i].window,
                      directed_rows[i].typed, directed_rows[i].res);
        end

        // Random phases: a fresh table each, then a start and mostly steps
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            drain_results();
            kind = $urandom_range(0, 7);
            if (phase == 4)
            begin
                load_table({64{1'b1}}, {64{1'b1}}, {64{1'b1}}, {64{1'b1}});
            end
            else if (phase == 7)
            begin
                load_table(64'h0, 64'h0, 64'h0, 64'h0);
            end
            else if (kind == 7)
            begin
                case ($urandom_range(0, 3))
                    0:       mask = 8'h03;
                    1:       mask = 8'h07;
                    2:       mask = 8'h0F;
                    default: mask = 8'hFF;
                endcase
                load_table({$urandom, $urandom}, {$urandom, $urandom},
                           {$urandom, $urandom} & {8{mask}}, {$urandom, $urandom} & {8{mask}});
            end
            else
            begin
                random_counts(kind == 6, counts_lo, counts_hi);
                load_table({$urandom, $urandom}, {$urandom, $urandom}, counts_lo, counts_hi);
            end
            no_idle = (phase % 4 == 3);
            if (phase == 2)
                hold_off_req = 1'b1;
            send_beat(tansd_pkg::CMD_START, 6'($urandom_range(0, 63)),
                      6'($urandom_range(0, 63)), 1'b0, '0);
            for (int n = 1; n < ITEMS_PER_PHASE; n++)
            begin
                if ($urandom_range(0, 99) < 8)
                    send_beat(tansd_pkg::CMD_START, 6'($urandom_range(0, 63)),
                              6'($urandom_range(0, 63)), 1'b0, '0);
                else
                    send_beat(tansd_pkg::CMD_STEP, 6'($urandom_range(0, 63)),
                              6'($urandom_range(0, 63)), 1'b0, '0);
            end
        end

        drain_results();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("PASS tans_symbol_decoder");
        else
            $display("FAIL tans_symbol_decoder");
        $finish;
    end

endmodule
